FILE: hw/rtl/bilinear_wrap_texture_sampler_unit_defines.svh
// Assertion macros for the texture sampler.
// BWTS_ASSERT checks a property with reset disabling it.
// BWTS_ASSERT_ALWAYS checks a property at every edge, also during reset.
`ifndef BILINEAR_WRAP_TEXTURE_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_WRAP_TEXTURE_SAMPLER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BWTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BWTS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BWTS_ASSERT(lbl, prop, msg)
`define BWTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/bwts_pkg.sv
package bwts_pkg;

	localparam int CH_W     = 16;
	localparam int TEXEL_W  = 3 * CH_W;
	localparam int IDX_W    = 8;
	localparam int SIZE_W   = 9;
	localparam int ADDR_W   = 2 * IDX_W;
	localparam int DEPTH    = 1 << ADDR_W;
	localparam int FRAC_W   = 16;
	localparam int WGT_W    = FRAC_W + 1;
	localparam int HSUM_W   = CH_W + WGT_W;
	localparam int ACC_W    = HSUM_W + WGT_W;
	localparam int COORD_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [SIZE_W-1:0] MAX_SIZE = 9'd256;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEX_WIDTH  = 2'd0,
		REG_TEX_HEIGHT = 2'd1,
		REG_U_SHIFT    = 2'd2,
		REG_V_SHIFT    = 2'd3
	} cfg_reg_t;

	// Request kinds carried in tuser.
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// Load enables of the blend stages.
	typedef struct packed {
		logic en4;
		logic en5;
	} bwts_ctl_t;

endpackage

FILE: hw/rtl/bwts_ram.sv
module bwts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/bwts_axis.sv
module bwts_axis import bwts_pkg::*; (
	input  logic [FRAC_W-1:0] tf,
	input  logic [SIZE_W-1:0] size,
	output logic [IDX_W-1:0]  i0,
	output logic [IDX_W-1:0]  i1,
	output logic [FRAC_W-1:0] frac
);

	localparam int P_W = FRAC_W + SIZE_W + 1;

	logic [P_W-1:0]    pos;
	logic [SIZE_W-1:0] nxt;

	// Only the fractional part of the coordinate moves the wrapped index, since the
	// integer part times the size is a whole number of tiles. The texel position
	// within the tile then lies between minus one and size minus one.
	assign pos  = P_W'(tf * size) - P_W'(32'h8000);
	assign frac = pos[FRAC_W-1:0];

	always_comb begin
		if (pos[P_W-1]) begin
			i0 = IDX_W'(size - SIZE_W'(1));
		end else begin
			i0 = pos[FRAC_W +: IDX_W];
		end
		nxt = {1'b0, i0} + SIZE_W'(1);
		i1  = (nxt == size) ? '0 : nxt[IDX_W-1:0];
	end

endmodule

FILE: hw/rtl/bwts_blend.sv
module bwts_blend import bwts_pkg::*; (
	input  logic                   clk,
	input  bwts_ctl_t              ctl,
	input  logic [TEXEL_W-1:0]     texel [4],
	input  logic [FRAC_W-1:0]      s_frac,
	input  logic [FRAC_W-1:0]      t_frac,
	output logic [TEXEL_W-1:0]     result
);

	logic [WGT_W-1:0]  ws0, ws1, wt0_s4, wt1_s4;
	logic [HSUM_W-1:0] h_s4 [2][3];
	logic [ACC_W-1:0]  acc  [3];
	logic [TEXEL_W-1:0] res_q;

	assign ws1 = {1'b0, s_frac};
	assign ws0 = (WGT_W'(1) << FRAC_W) - ws1;

	// Horizontal blend of each row, one product per texel and channel.
	always_ff @(posedge clk) begin
		if (ctl.en4) begin
			for (int b = 0; b < 2; b++) begin
				for (int c = 0; c < 3; c++) begin
					h_s4[b][c] <= HSUM_W'(texel[2*b][c*CH_W +: CH_W] * ws0)
						+ HSUM_W'(texel[2*b+1][c*CH_W +: CH_W] * ws1);
				end
			end
			wt1_s4 <= {1'b0, t_frac};
			wt0_s4 <= (WGT_W'(1) << FRAC_W) - {1'b0, t_frac};
		end
	end

	// Vertical blend and rounding to the nearest channel value.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc[c] = ACC_W'(h_s4[0][c] * wt0_s4) + ACC_W'(h_s4[1][c] * wt1_s4)
				+ (ACC_W'(1) << (2 * FRAC_W - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en5) begin
			for (int c = 0; c < 3; c++) begin
				res_q[c*CH_W +: CH_W] <= acc[c][2*FRAC_W +: CH_W];
			end
		end
	end

	assign result = res_q;

endmodule

FILE: hw/rtl/bilinear_wrap_texture_sampler_unit.sv
// Bilinear texture sampler with tiled addressing. Texel writes (tuser 0) and
// sample requests (tuser 1) share one input stream and stay in order, so a sample
// sees every write accepted before it. One item is taken per cycle while the output
// is not stalled; a sample gives one result, a write gives none. The rate is set by
// four replicated texel RAMs, each written by every texel write and each reading one
// of the four neighbours, so all neighbours come out of one read. The store is not
// cleared after reset; a texel must be written before it is sampled.
`include "bilinear_wrap_texture_sampler_unit_defines.svh"
module bilinear_wrap_texture_sampler_unit import bwts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// texel_x, texel_y, in_red, in_green, in_blue, coord_u, coord_v
	input  logic [127:0]         s_axis_tdata,
	// req_type
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// out_red, out_green, out_blue
	output logic [47:0]          m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic [SIZE_W-1:0] width_q, height_q, cfg_size;
	logic [FRAC_W-1:0] ushift_q, vshift_q;

	logic en1, en2, en3;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic smp_s1, smp_s2, smp_s3;
	logic [IDX_W-1:0]   x_s1, y_s1;
	logic [TEXEL_W-1:0] rgb_s1, rgb_s2;
	logic [FRAC_W-1:0]  tfu_s1, tfv_s1;
	logic [IDX_W-1:0]   x0_s2, x1_s2, y0_s2, y1_s2;
	logic [FRAC_W-1:0]  s_s2, t_s2, s_s3, t_s3;
	logic [IDX_W-1:0]   ux0, ux1, vy0, vy1;
	logic [FRAC_W-1:0]  ufr, vfr;
	logic [TEXEL_W-1:0] texel [4];
	logic [ADDR_W-1:0]  raddr [4];
	logic               ram_we;
	bwts_ctl_t          ctl;

	// Configuration writes; sizes are clamped to one through the store size.
	assign cfg_ready = 1'b1;
	always_comb begin
		if (cfg_data[SIZE_W-1:0] == '0) begin
			cfg_size = SIZE_W'(1);
		end else if (cfg_data[SIZE_W-1:0] > MAX_SIZE) begin
			cfg_size = MAX_SIZE;
		end else begin
			cfg_size = cfg_data[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAX_SIZE;
			height_q <= MAX_SIZE;
			ushift_q <= '0;
			vshift_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEX_WIDTH:  width_q  <= cfg_size;
				REG_TEX_HEIGHT: height_q <= cfg_size;
				REG_U_SHIFT:    ushift_q <= cfg_data[FRAC_W-1:0];
				REG_V_SHIFT:    vshift_q <= cfg_data[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage load enables; a stage takes new data when empty or when it moves on.
	assign ctl.en5 = !v5_s5 || m_axis_tready;
	assign ctl.en4 = !v4_s4 || ctl.en5;
	assign en3     = !v3_s3 || ctl.en4;
	assign en2     = !v2_s2 || en3;
	assign en1     = !v1_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= s_axis_tvalid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (ctl.en4) v4_s4 <= v3_s3 && smp_s3;
			if (ctl.en5) v5_s5 <= v4_s4;
		end
	end

	// Stage 1: accepted item, with the fractional coordinates shifted.
	always_ff @(posedge clk) begin
		if (en1) begin
			smp_s1 <= s_axis_tuser;
			x_s1   <= s_axis_tdata[7:0];
			y_s1   <= s_axis_tdata[15:8];
			rgb_s1 <= s_axis_tdata[63:16];
			tfu_s1 <= s_axis_tdata[79:64] + ushift_q;
			tfv_s1 <= s_axis_tdata[111:96] + vshift_q;
		end
	end

	bwts_axis u_axis_u (.tf(tfu_s1), .size(width_q),  .i0(ux0), .i1(ux1), .frac(ufr));
	bwts_axis u_axis_v (.tf(tfv_s1), .size(height_q), .i0(vy0), .i1(vy1), .frac(vfr));

	// Stage 2: wrapped neighbour indices; a write keeps its address in x0 and y0.
	always_ff @(posedge clk) begin
		if (en2) begin
			smp_s2 <= smp_s1;
			rgb_s2 <= rgb_s1;
			x0_s2  <= (smp_s1 == REQ_SAMPLE) ? ux0 : x_s1;
			y0_s2  <= (smp_s1 == REQ_SAMPLE) ? vy0 : y_s1;
			x1_s2  <= ux1;
			y1_s2  <= vy1;
			s_s2   <= ufr;
			t_s2   <= vfr;
		end
	end

	// Texel store: every write goes to all four copies, each copy reads one neighbour.
	assign ram_we   = en3 && v2_s2 && (smp_s2 == REQ_WRITE);
	assign raddr[0] = {y0_s2, x0_s2};
	assign raddr[1] = {y0_s2, x1_s2};
	assign raddr[2] = {y1_s2, x0_s2};
	assign raddr[3] = {y1_s2, x1_s2};

	for (genvar g = 0; g < 4; g++) begin : g_bank
		bwts_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_ram (
			.clk  (clk),
			.we   (ram_we),
			.waddr({y0_s2, x0_s2}),
			.wdata(rgb_s2),
			.re   (en3),
			.raddr(raddr[g]),
			.rdata(texel[g])
		);
	end

	// Stage 3: texels arrive from the RAMs, weights travel alongside.
	always_ff @(posedge clk) begin
		if (en3) begin
			smp_s3 <= smp_s2;
			s_s3   <= s_s2;
			t_s3   <= t_s2;
		end
	end

	bwts_blend u_blend (
		.clk   (clk),
		.ctl   (ctl),
		.texel (texel),
		.s_frac(s_s3),
		.t_frac(t_s3),
		.result(m_axis_tdata)
	);

	assign m_axis_tvalid = v5_s5;

	`BWTS_ASSERT(a_u_wrap, v1_s1 |-> (ux0 < width_q[IDX_W-1:0] || width_q == MAX_SIZE) && ({1'b0, ux1} < width_q), "u index out of range")
	`BWTS_ASSERT(a_v_wrap, v1_s1 |-> ({1'b0, vy0} < height_q) && ({1'b0, vy1} < height_q), "v index out of range")
	`BWTS_ASSERT(a_stall, v4_s4 && v5_s5 && !m_axis_tready |=> v4_s4, "blend stage lost under stall")

endmodule

FILE: sim/bilinear_wrap_texture_sampler_unit_tb.sv
`timescale 1ns / 1ps

module bilinear_wrap_texture_sampler_unit_tb;
	import bwts_pkg::*;

	// Texel store, sampling state and queue of expected blended colors.
	class texel_scoreboard;
		logic [TEXEL_W-1:0] texels [DEPTH];
		bit                 written [DEPTH];
		int                 width_eff;
		int                 height_eff;
		logic [31:0]        shift_u;
		logic [31:0]        shift_v;
		logic [TEXEL_W-1:0] expected_colors [$];
		int                 mismatches;

		function new();
			width_eff = 256;
			height_eff = 256;
			shift_u = '0;
			shift_v = '0;
			mismatches = 0;
		endfunction

		// Size registers use nine bits; zero acts as one, large values saturate.
		function int clip_size(logic [31:0] d);
			int v;
			v = d[SIZE_W-1:0];
			if (v < 1) return 1;
			if (v > 256) return 256;
			return v;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [31:0] d);
			case (idx)
				REG_TEX_WIDTH: width_eff = clip_size(d);
				REG_TEX_HEIGHT: height_eff = clip_size(d);
				REG_U_SHIFT: shift_u = d;
				REG_V_SHIFT: shift_v = d;
				default: ;
			endcase
		endfunction

		// Split a shifted and scaled Q16.16 coordinate into wrapped indices and a fraction.
		function void split_axis(logic [31:0] c, logic [31:0] sh, int size,
				output int i0, output int i1, output longint fr);
			longint t, pos, fl, m;
			t = longint'($signed(c)) + longint'($signed(sh));
			pos = t * size - 32768;
			fl = pos >>> 16;
			fr = pos & 65535;
			m = fl % size;
			if (m < 0) m += size;
			i0 = int'(m);
			i1 = int'((m + 1) % size);
		endfunction

		function void corner_addrs(logic [31:0] u, logic [31:0] v, output int addr [4]);
			int x0, x1, y0, y1;
			longint s, t;
			split_axis(u, shift_u, width_eff, x0, x1, s);
			split_axis(v, shift_v, height_eff, y0, y1, t);
			addr[0] = y0 * 256 + x0;
			addr[1] = y0 * 256 + x1;
			addr[2] = y1 * 256 + x0;
			addr[3] = y1 * 256 + x1;
		endfunction

		// Note one accepted input transaction.
		function void note_input(logic kind, logic [127:0] d);
			int x0, x1, y0, y1, a;
			longint s, t;
			longint unsigned acc, ws [2], wt [2];
			int xs [2], ys [2];
			logic [TEXEL_W-1:0] color;
			if (kind == REQ_WRITE) begin
				a = d[15:8] * 256 + d[7:0];
				texels[a] = d[63:16];
				written[a] = 1;
				return;
			end
			split_axis(d[95:64], shift_u, width_eff, x0, x1, s);
			split_axis(d[127:96], shift_v, height_eff, y0, y1, t);
			xs[0] = x0; xs[1] = x1; ys[0] = y0; ys[1] = y1;
			ws[0] = 65536 - s; ws[1] = s;
			wt[0] = 65536 - t; wt[1] = t;
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int b = 0; b < 2; b++)
					for (int i = 0; i < 2; i++)
						acc += longint'(texels[ys[b] * 256 + xs[i]][c*CH_W +: CH_W])
							* ws[i] * wt[b];
				acc = (acc + 64'h8000_0000) >> 32;
				color[c*CH_W +: CH_W] = acc[CH_W-1:0];
			end
			expected_colors.push_back(color);
		endfunction

		// Compare one output transaction with the oldest expected color.
		function void check_result(logic [47:0] got);
			logic [TEXEL_W-1:0] want;
			if (expected_colors.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %h", got);
				return;
			end
			want = expected_colors.pop_front();
			for (int c = 0; c < 3; c++)
				if (got[c*CH_W +: CH_W] !== want[c*CH_W +: CH_W]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Channel %0d mismatch: expected %h, got %h",
							c, want[c*CH_W +: CH_W], got[c*CH_W +: CH_W]);
				end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [127:0]         s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [47:0]          m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	texel_scoreboard sb;
	bit              sender_busy_mode;
	bit              receiver_busy_mode;
	bit              hold_request;
	bit              hold_active;
	int              rx_gap;
	int              cycle_count;
	int              items_sent;

	bilinear_wrap_texture_sampler_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Timeout guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1500000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Receiver: random stalls per result, plus one long hold-off.
	always @(negedge clk) begin
		if (hold_active)
			m_axis_tready <= 1'b0;
		else if (rx_gap > 0) begin
			m_axis_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else
			m_axis_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			rx_gap <= receiver_busy_mode ? $urandom_range(12) : 0;
	end

	initial begin
		hold_active = 0;
		wait (hold_request);
		@(posedge clk);
		hold_active = 1;
		repeat (400) @(posedge clk);
		hold_active = 0;
	end

	// Offer one item, after a random gap in sender busy mode, and wait until it is taken.
	task automatic send_item(logic kind, logic [127:0] d);
		int gap;
		gap = sender_busy_mode ? $urandom_range(12) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(kind, d);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_texel(logic [7:0] x, logic [7:0] y, logic [47:0] rgb);
		send_item(REQ_WRITE, {64'($urandom) << 32 | 64'($urandom), rgb, y, x});
	endtask

	// Make sure all four neighbours hold data, then request the sample.
	task automatic sample_at(logic [31:0] u, logic [31:0] v);
		int addr [4];
		sb.corner_addrs(u, v, addr);
		for (int i = 0; i < 4; i++)
			if (!sb.written[addr[i]])
				write_texel(8'(addr[i] % 256), 8'(addr[i] / 256),
					{16'($urandom), 16'($urandom), 16'($urandom)});
		send_item(REQ_SAMPLE, {v, u, 48'($urandom), 16'($urandom)});
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_colors.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		@(negedge clk);
	endtask

	task automatic configure(logic [31:0] w, logic [31:0] h, logic [31:0] su,
			logic [31:0] sv);
		wait_drained();
		write_reg(REG_TEX_WIDTH, w);
		write_reg(REG_TEX_HEIGHT, h);
		write_reg(REG_U_SHIFT, su);
		write_reg(REG_V_SHIFT, sv);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			2: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(255)
				: 32'h7FFF_FFFF - $urandom_range(255);
			default: return {16'($urandom_range(3)), 16'($urandom)};
		endcase
	endfunction

	// Random part of one phase; count includes the texel writes a sample needs.
	task automatic random_items(int count, bit with_hold);
		int stop;
		int mid;
		bit drained;
		stop = items_sent + count;
		mid = items_sent + count / 2;
		drained = 0;
		for (int n = 0; items_sent < stop; n++) begin
			if (n % 97 == 0) begin
				sender_busy_mode = $urandom_range(3) != 0;
				receiver_busy_mode = $urandom_range(3) != 0;
			end
			if (with_hold && n == 40) begin
				sender_busy_mode = 0;
				hold_request = 1;
			end
			if (!drained && items_sent >= mid) begin
				wait_drained();
				drained = 1;
			end
			if ($urandom_range(9) < 4)
				write_texel(8'($urandom), 8'($urandom), {16'($urandom), 16'($urandom),
					16'($urandom)});
			else
				sample_at(pick_coord(), pick_coord());
		end
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		items_sent = 0;
		rx_gap = 0;
		hold_request = 0;
		sender_busy_mode = 1;
		receiver_busy_mode = 1;
		s_axis_tvalid = 0;
		s_axis_tuser = REQ_WRITE;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_index = REG_TEX_WIDTH;
		cfg_data = '0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: corner texels at extreme values, then samples on tiny, clamped and full-size textures.
		write_texel(8'd0, 8'd0, 48'h0);
		write_texel(8'd255, 8'd255, 48'hFFFF_FFFF_FFFF);
		write_texel(8'd1, 8'd0, 48'hFFFF_0000_FFFF);
		write_texel(8'd0, 8'd1, 48'h0000_FFFF_0000);
		write_texel(8'd1, 8'd1, 48'h1234_8000_7FFF);
		configure(32'd1, 32'd1, 32'd0, 32'd0);
		sample_at(32'h0, 32'h0);
		sample_at(32'h8000_0000, 32'h7FFF_FFFF);
		configure(32'd2, 32'd2, 32'd0, 32'd0);
		sample_at(32'h0000_4000, 32'h0000_4000);
		sample_at(32'h0000_C000, 32'h0000_C000);
		sample_at(32'h0000_BFFF, 32'h0000_4001);
		sample_at(32'hFFFF_FFFF, 32'h0001_0000);
		configure(32'd0, 32'd511, 32'h7FFF_FFFF, 32'h8000_0000);
		sample_at(32'h7FFF_FFFF, 32'h8000_0000);
		sample_at(32'h0, 32'h0);
		configure(32'd256, 32'd256, 32'd0, 32'd0);
		sample_at(32'h0000_0080, 32'h0000_0080);
		sample_at(32'hFFFF_FF80, 32'h0000_FF80);
		sample_at(32'h8000_0000, 32'h8000_0000);
		sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);

		// Random phases over several texture sizes and shifts.
		random_items(250, 1);
		configure(32'd3, 32'd5, $urandom, $urandom);
		random_items(250, 0);
		configure(32'd256, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
		random_items(250, 0);
		configure(32'd200, 32'd77, $urandom, $urandom);
		random_items(250, 0);
		configure(32'h1FF, 32'd256, {16'($urandom_range(3)), 16'($urandom)}, 32'd0);
		random_items(250, 0);

		s_axis_tvalid <= 1'b0;
		while (sb.expected_colors.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.mismatches == 0 && sb.expected_colors.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: bilinear_wrap_texture_sampler_unit.f
+incdir+hw/rtl
hw/rtl/bwts_pkg.sv
hw/rtl/bwts_ram.sv
hw/rtl/bwts_axis.sv
hw/rtl/bwts_blend.sv
hw/rtl/bilinear_wrap_texture_sampler_unit.sv
sim/bilinear_wrap_texture_sampler_unit_tb.sv
